// ===== sv/ic3_pkg.sv =====
package ic3_pkg;

   localparam int LINE_MAX    = 1024;
   localparam int LINE_BITS   = $clog2(LINE_MAX);
   localparam int SLOT_COUNT  = 3;
   localparam int STORE_DEPTH = SLOT_COUNT * LINE_MAX;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int PIXEL_BITS  = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int KROW_BITS   = 3 * WEIGHT_BITS;
   localparam int ACC_BITS    = 36;
   localparam int KSUM_BITS   = 20;
   localparam int PROD_BITS   = WEIGHT_BITS + PIXEL_BITS + 1;
   localparam int ROW_BITS    = 16;
   localparam int COL_BITS    = 10;
   localparam int WIDTH_BITS  = 11;
   localparam int GRAY_BITS   = 16;
   localparam int DIV_STEPS   = ACC_BITS;
   localparam int DCNT_BITS   = $clog2(DIV_STEPS + 1);
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAY_LIMIT    = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_TAPS,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic       accept;
      logic       tap_issue;
      logic       tap_first;
      logic [1:0] tap_row;
      logic [1:0] tap_col;
      logic       row_sel;
      logic       col_sel;
      logic       div_load;
   } cmd_type;

   typedef struct packed {
      logic row_prev_ok;
      logic row_cur_ok;
      logic col_prev_ok;
      logic col_cur_ok;
      logic div_done;
   } status_type;

endpackage

// ===== sv/ic3_ram.sv =====
module ic3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 3072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ic3_ctrl.sv =====
module ic3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_last_of_run,
   output ic3_pkg::cmd_type    cmd,
   input  ic3_pkg::status_type status
);
   import ic3_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0] tap_row_ff, tap_row_in;
   logic [1:0] tap_col_ff, tap_col_in;
   logic       drain_ff, drain_in;
   logic       row_sel_ff, row_sel_in;
   logic       col_sel_ff, col_sel_in;
   logic       next_col, next_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_row_ff <= '0;
         tap_col_ff <= '0;
         drain_ff   <= 1'b0;
         row_sel_ff <= 1'b0;
         col_sel_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tap_row_ff <= tap_row_in;
         tap_col_ff <= tap_col_in;
         drain_ff   <= drain_in;
         row_sel_ff <= row_sel_in;
         col_sel_ff <= col_sel_in;
      end
   end

   assign next_col = !col_sel_ff && status.col_cur_ok;
   assign next_row = !row_sel_ff && status.row_cur_ok;

   always_comb begin
      state_in   = state_ff;
      tap_row_in = tap_row_ff;
      tap_col_in = tap_col_ff;
      drain_in   = drain_ff;
      row_sel_in = row_sel_ff;
      col_sel_in = col_sel_ff;
      cmd           = '0;
      cmd.tap_row   = tap_row_ff;
      cmd.tap_col   = tap_col_ff;
      cmd.row_sel   = row_sel_ff;
      cmd.col_sel   = col_sel_ff;
      cmd.tap_first = (tap_row_ff == 2'd0) && (tap_col_ff == 2'd0);
      req_stall       = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_OUT);
      rsp_last_of_run = !(next_col || next_row);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if ((status.row_prev_ok || status.row_cur_ok) &&
                (status.col_prev_ok || status.col_cur_ok)) begin
               row_sel_in = !status.row_prev_ok;
               col_sel_in = !status.col_prev_ok;
               tap_row_in = 2'd0;
               tap_col_in = 2'd0;
               state_in   = ST_TAPS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TAPS: begin
            cmd.tap_issue = 1'b1;
            if (tap_col_ff == 2'd2) begin
               tap_col_in = 2'd0;
               if (tap_row_ff == 2'd2) begin
                  drain_in = 1'b0;
                  state_in = ST_DRAIN;
               end else begin
                  tap_row_in = tap_row_ff + 2'd1;
               end
            end else begin
               tap_col_in = tap_col_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               tap_row_in = 2'd0;
               tap_col_in = 2'd0;
               if (next_col) begin
                  col_sel_in = 1'b1;
                  state_in   = ST_TAPS;
               end else if (next_row) begin
                  row_sel_in = 1'b1;
                  col_sel_in = !status.col_prev_ok;
                  state_in   = ST_TAPS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/ic3_dp.sv =====
module ic3_dp (
   input  logic                clock,
   input  logic                reset,
   input  ic3_pkg::cmd_type     cmd,
   output ic3_pkg::status_type  status,
   input  logic                frame_restart,
   input  logic [15:0]         req_pixel_value,
   input  logic [47:0]         kernel_top,
   input  logic [47:0]         kernel_middle,
   input  logic [47:0]         kernel_bottom,
   input  logic [10:0]         frame_width,
   input  logic [15:0]         frame_height,
   input  logic [15:0]         gray_limit,
   output logic [15:0]         rsp_out_row,
   output logic [9:0]          rsp_out_col,
   output logic signed [35:0]  rsp_filtered_value,
   output logic                rsp_end_of_frame
);
   import ic3_pkg::*;

   logic [WIDTH_BITS-1:0] w_eff;
   logic [ROW_BITS-1:0]   h_eff;
   logic [ROW_BITS-1:0]   in_row_ff;
   logic [COL_BITS-1:0]   in_col_ff;
   logic [1:0]            in_slot_ff;
   logic [ROW_BITS-1:0]   cur_row_ff;
   logic [COL_BITS-1:0]   cur_col_ff;
   logic [1:0]            cur_slot_ff;
   logic                  wrap;
   logic [ROW_BITS-1:0]   row_now;
   logic [COL_BITS-1:0]   col_now;
   logic [1:0]            slot_now;
   logic                  row_end, col_end;
   logic [ROW_BITS-1:0]   out_row;
   logic [COL_BITS-1:0]   out_col;
   logic [1:0]            out_back, tap_back;
   logic [2:0]            slot_sum;
   logic [1:0]            tap_slot;
   logic [COL_BITS-1:0]   tap_col_idx;
   logic [KROW_BITS-1:0]  krow;
   logic signed [WEIGHT_BITS-1:0] weight;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [PIXEL_BITS-1:0] rd_pixel;
   logic signed [WEIGHT_BITS-1:0] weight_d_ff;
   logic                  issue_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                  prod_valid_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [KSUM_BITS-1:0] ksum_ff;
   logic [ACC_BITS-1:0]   quo_ff;
   logic [KSUM_BITS-1:0]  rem_ff;
   logic [KSUM_BITS-1:0]  dvs_ff;
   logic [DCNT_BITS-1:0]  dcnt_ff;
   logic                  neg_ff;
   logic [KSUM_BITS:0]    trial;
   logic [KSUM_BITS:0]    shifted;

   assign w_eff = (frame_width == '0) ? WIDTH_BITS'(1) :
                  (frame_width > WIDTH_BITS'(LINE_MAX)) ? WIDTH_BITS'(LINE_MAX) : frame_width;
   assign h_eff = (frame_height == '0) ? ROW_BITS'(1) : frame_height;

   assign wrap     = (in_row_ff >= h_eff) || ({1'b0, in_col_ff} >= w_eff);
   assign row_now  = wrap ? '0 : in_row_ff;
   assign col_now  = wrap ? '0 : in_col_ff;
   assign slot_now = wrap ? 2'd0 : in_slot_ff;
   assign col_end  = ({1'b0, col_now} + WIDTH_BITS'(1)) >= w_eff;
   assign row_end  = ({1'b0, row_now} + 17'd1) >= {1'b0, h_eff};

   always_ff @(posedge clock) begin
      if (reset || frame_restart) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_slot_ff <= 2'd0;
      end else if (cmd.accept) begin
         if (col_end) begin
            in_col_ff <= '0;
            if (row_end) begin
               in_row_ff  <= '0;
               in_slot_ff <= 2'd0;
            end else begin
               in_row_ff  <= row_now + ROW_BITS'(1);
               in_slot_ff <= (slot_now == 2'd2) ? 2'd0 : slot_now + 2'd1;
            end
         end else begin
            in_row_ff  <= row_now;
            in_col_ff  <= col_now + COL_BITS'(1);
            in_slot_ff <= slot_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_row_ff  <= row_now;
         cur_col_ff  <= col_now;
         cur_slot_ff <= slot_now;
      end
   end

   assign status.row_prev_ok = (cur_row_ff != '0);
   assign status.row_cur_ok  = (cur_row_ff == h_eff - ROW_BITS'(1));
   assign status.col_prev_ok = (cur_col_ff != '0);
   assign status.col_cur_ok  = ({1'b0, cur_col_ff} == w_eff - WIDTH_BITS'(1));
   assign status.div_done    = (dcnt_ff == '0);

   assign out_row  = cmd.row_sel ? cur_row_ff : cur_row_ff - ROW_BITS'(1);
   assign out_col  = cmd.col_sel ? cur_col_ff : cur_col_ff - COL_BITS'(1);
   assign out_back = cmd.row_sel ? 2'd0 : 2'd1;

   // Neighbor rows are tracked as a distance back from the newest row.
   always_comb begin
      case (cmd.tap_row)
         2'd0:    tap_back = (out_row == '0) ? out_back : out_back + 2'd1;
         2'd2:    tap_back = (out_row == h_eff - ROW_BITS'(1)) ? out_back : out_back - 2'd1;
         default: tap_back = out_back;
      endcase
      case (cmd.tap_col)
         2'd0:    tap_col_idx = (out_col == '0) ? out_col : out_col - COL_BITS'(1);
         2'd2:    tap_col_idx = ({1'b0, out_col} == w_eff - WIDTH_BITS'(1)) ?
                                out_col : out_col + COL_BITS'(1);
         default: tap_col_idx = out_col;
      endcase
      case (cmd.tap_row)
         2'd0:    krow = kernel_top;
         2'd2:    krow = kernel_bottom;
         default: krow = kernel_middle;
      endcase
      case (cmd.tap_col)
         2'd0:    weight = krow[15:0];
         2'd2:    weight = krow[47:32];
         default: weight = krow[31:16];
      endcase
   end

   assign slot_sum = {1'b0, cur_slot_ff} + 3'd3 - {1'b0, tap_back};
   assign tap_slot = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
   assign rd_addr  = {tap_slot, tap_col_idx};
   assign wr_addr  = {slot_now, col_now};

   ic3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_value[PIXEL_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         issue_ff      <= cmd.tap_issue;
         prod_valid_ff <= issue_ff;
      end
   end

   always_ff @(posedge clock) begin
      weight_d_ff <= weight;
      prod_ff     <= weight_d_ff * $signed({1'b0, rd_pixel});
      if (cmd.tap_issue) begin
         ksum_ff <= cmd.tap_first ? KSUM_BITS'(weight) : ksum_ff + KSUM_BITS'(weight);
      end
      if (cmd.tap_issue && cmd.tap_first) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_BITS'(prod_ff);
      end
   end

   // Restoring divider on magnitudes, one quotient bit per cycle.
   assign shifted = {rem_ff, quo_ff[ACC_BITS-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_load) begin
         dcnt_ff <= DCNT_BITS'(DIV_STEPS);
      end else if (dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - DCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= acc_ff[ACC_BITS-1] ? ACC_BITS'(-acc_ff) : ACC_BITS'(acc_ff);
         dvs_ff <= ksum_ff[KSUM_BITS-1] ? KSUM_BITS'(-ksum_ff) : KSUM_BITS'(ksum_ff);
         neg_ff <= acc_ff[ACC_BITS-1] ^ ksum_ff[KSUM_BITS-1];
      end else if (dcnt_ff != '0) begin
         if (trial[KSUM_BITS]) begin
            rem_ff <= shifted[KSUM_BITS-1:0];
            quo_ff <= {quo_ff[ACC_BITS-2:0], 1'b0};
         end else begin
            rem_ff <= trial[KSUM_BITS-1:0];
            quo_ff <= {quo_ff[ACC_BITS-2:0], 1'b1};
         end
      end
   end

   always_comb begin
      if (ksum_ff == '0) begin
         rsp_filtered_value = acc_ff;
      end else if (neg_ff && (quo_ff != '0)) begin
         rsp_filtered_value = '0;
      end else if (quo_ff > ACC_BITS'(gray_limit)) begin
         rsp_filtered_value = ACC_BITS'(gray_limit);
      end else begin
         rsp_filtered_value = quo_ff;
      end
   end

   assign rsp_out_row      = out_row;
   assign rsp_out_col      = out_col;
   assign rsp_end_of_frame = (out_row == h_eff - ROW_BITS'(1)) &&
                             ({1'b0, out_col} == w_eff - WIDTH_BITS'(1));

endmodule

// ===== sv/image_convolution_3x3_clamped.sv =====
// 3x3 convolution over a raster-order gray pixel stream with edge clamping.
// Each pixel beat is written into a three-row line store; it then releases
// zero to four filtered results, which leave in raster order tagged with
// their row and column. A pixel is accepted in the idle state and the block then
// stalls its input until every result that pixel releases has been taken.
// After the accept the planning state decides which results are due. Each
// result then passes through line-store reads of its nine taps (one read
// port), the multiply-accumulate drain, a divider load, the bit-serial
// divider (36 quotient steps and the state that sees it finish), and the
// result port, where it waits while rsp_stall is high. A pixel that releases
// nothing goes from the planning state straight back to idle. Configuration
// is written through the csr port while the block is idle, a rule the block
// itself does not enforce; writing the frame width or height restarts the
// frame at pixel (0,0). The line store needs no clearing after reset, since
// no read reaches a location not written earlier in the same frame.
module image_convolution_3x3_clamped (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_pixel_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_out_row,
   output logic [9:0]         rsp_out_col,
   output logic signed [35:0] rsp_filtered_value,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_frame,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);
   import ic3_pkg::*;

   // Configuration registers, reset to an identity kernel over 1024x1024.
   logic [KROW_BITS-1:0]  kernel_top_ff;
   logic [KROW_BITS-1:0]  kernel_middle_ff;
   logic [KROW_BITS-1:0]  kernel_bottom_ff;
   logic [WIDTH_BITS-1:0] frame_width_ff;
   logic [ROW_BITS-1:0]   frame_height_ff;
   logic [GRAY_BITS-1:0]  gray_limit_ff;
   logic                  csr_write;
   logic                  frame_restart;
   cmd_type               cmd;
   status_type            status;

   // The register file can always take a write.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_top_ff    <= '0;
         kernel_middle_ff <= KROW_BITS'(65536);
         kernel_bottom_ff <= '0;
         frame_width_ff   <= WIDTH_BITS'(1024);
         frame_height_ff  <= ROW_BITS'(1024);
         gray_limit_ff    <= GRAY_BITS'(255);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KERNEL_TOP:    kernel_top_ff    <= csr_data;
            CSR_KERNEL_MIDDLE: kernel_middle_ff <= csr_data;
            CSR_KERNEL_BOTTOM: kernel_bottom_ff <= csr_data;
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data[ROW_BITS-1:0];
            CSR_GRAY_LIMIT:    gray_limit_ff    <= csr_data[GRAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // A geometry change puts the next pixel beat at the frame origin.
   assign frame_restart = csr_write &&
                          ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   ic3_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .status          (status)
   );

   ic3_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .frame_restart      (frame_restart),
      .req_pixel_value    (req_pixel_value),
      .kernel_top         (kernel_top_ff),
      .kernel_middle      (kernel_middle_ff),
      .kernel_bottom      (kernel_bottom_ff),
      .frame_width        (frame_width_ff),
      .frame_height       (frame_height_ff),
      .gray_limit         (gray_limit_ff),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_end_of_frame   (rsp_end_of_frame)
   );

   // Results are only offered while the input side is held off.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("result beat offered while input is open");

   // A pixel beat is never followed directly by a result beat.
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result offered in the cycle after a pixel beat");

   // The frame's final result closes the run of its pixel.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_end_of_frame) |-> rsp_last_of_run)
      else $error("end of frame without last of run");

endmodule
